// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SQB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define SQB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sqb_pkg.sv -----
package sqb_pkg;

    localparam int MaxQuads      = 1024;
    localparam int MaxSlots      = 32;
    localparam int SineTableBits = 10;
    localparam int FifoDepth     = 2;

    localparam int QuadW      = $clog2(MaxQuads + 1);
    localparam int SlotCntW   = $clog2(MaxSlots + 1);
    localparam int SlotIdxW   = $clog2(MaxSlots);
    localparam int FifoPtrW   = $clog2(FifoDepth);
    localparam int FifoCntW   = $clog2(FifoDepth + 1);
    localparam int SineIdxW   = SineTableBits - 2;
    localparam int SineEntries = 1 << SineIdxW;

    localparam logic KindVertex = 1'b0;
    localparam logic KindFlush  = 1'b1;
    localparam logic OpSubmit   = 1'b0;
    localparam logic OpEndScene = 1'b1;

    typedef logic [16:0] t_sine_tab [SineEntries];

    typedef struct packed {
        logic               has_flush;
        logic [12:0]        flush_idx;
        logic [5:0]         flush_slots;
        logic               has_quad;
        logic [4:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic [31:0]        color;
        logic [63:0]        coords_right;
        logic [63:0]        coords_left;
    } t_job;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic [31:0]        packed_color;
        logic [31:0]        tex_coord;
        logic [4:0]         slot;
        logic [12:0]        flushed_indices;
        logic [5:0]         slots_in_use;
        logic               last;
    } t_res;

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        longint    x;
        longint    x2;
        longint    t;
        for (int i = 0; i < SineEntries; i++) begin
            x  = longint'(i) << (18 - SineTableBits);
            x2 = (x * x) >> 16;
            t  = (4640 * x2) >> 16;
            t  = ((42048 - t) * x2) >> 16;
            t  = 102944 - t;
            t  = (t * x) >> 16;
            if (t > 65536) begin
                t = 65536;
            end
            tab[i] = 17'(t);
        end
        return tab;
    endfunction

    localparam t_sine_tab SineTab = build_sine_tab();

    function automatic logic signed [17:0] sine_q16(logic [15:0] p);
        logic [1:0]        quad;
        logic [SineIdxW:0] f;
        logic [16:0]       mag;
        quad = p[15:14];
        f    = (SineIdxW + 1)'(p[13:16-SineTableBits]);
        if (quad[0]) begin
            f = (SineIdxW + 1)'(SineEntries) - f;
        end
        if (f[SineIdxW]) begin
            mag = 17'd65536;
        end else begin
            mag = SineTab[f[SineIdxW-1:0]];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic [12:0] six_times(logic [QuadW-1:0] q);
        logic [12:0] x;
        x = 13'(q);
        return (x << 2) + (x << 1);
    endfunction

endpackage

// ----- sv/sqb_in_if.sv -----
interface sqb_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        angle;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic [31:0]        color_rgba;
    logic [30:0]        texture_id;
    logic [63:0]        coords_right;
    logic [63:0]        coords_left;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, angle, scale_x, scale_y,
                    color_rgba, texture_id, coords_right, coords_left, input ready);
    modport sink (input valid, opcode, pos_x, pos_y, pos_z, angle, scale_x, scale_y,
                  color_rgba, texture_id, coords_right, coords_left, output ready);
endinterface

// ----- sv/sqb_out_if.sv -----
interface sqb_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        packed_color;
    logic [31:0]        tex_coord;
    logic [4:0]         slot;
    logic [12:0]        flushed_indices;
    logic [5:0]         slots_in_use;
    logic               last;

    modport source (output valid, kind, vert_x, vert_y, vert_z, packed_color, tex_coord, slot,
                    flushed_indices, slots_in_use, last, input ready);
    modport sink (input valid, kind, vert_x, vert_y, vert_z, packed_color, tex_coord, slot,
                  flushed_indices, slots_in_use, last, output ready);
endinterface

// ----- sv/sqb_front.sv -----
module sqb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sqb_in_if.sink        i_item,
    output sqb_pkg::t_job o_job,
    output logic          o_push,
    input  logic          i_full
);

    typedef enum logic [1:0] {F_IDLE, F_SEARCH, F_PUSH} t_fstate;

    t_fstate                          r_state;
    sqb_pkg::t_job                    r_job;
    logic [30:0]                      r_tex;
    logic [sqb_pkg::SlotCntW-1:0]     r_idx;
    logic [sqb_pkg::SlotCntW-1:0]     r_slots_used;
    logic [sqb_pkg::QuadW-1:0]        r_quads;
    logic [30:0]                      r_table [sqb_pkg::MaxSlots];

    assign i_item.ready = (r_state == F_IDLE);
    assign o_push       = (r_state == F_PUSH) && !i_full;
    assign o_job        = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_slots_used <= sqb_pkg::SlotCntW'(1);
            r_quads      <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_item.valid) begin
                        r_job.pos_x        <= i_item.pos_x;
                        r_job.pos_y        <= i_item.pos_y;
                        r_job.pos_z        <= i_item.pos_z;
                        r_job.angle        <= i_item.angle;
                        r_job.scale_x      <= i_item.scale_x;
                        r_job.scale_y      <= i_item.scale_y;
                        r_job.color        <= i_item.color_rgba;
                        r_job.coords_right <= i_item.coords_right;
                        r_job.coords_left  <= i_item.coords_left;
                        r_job.slot         <= '0;
                        r_job.has_flush    <= (i_item.opcode == sqb_pkg::OpEndScene) ||
                                              (32'(r_quads) >= sqb_pkg::MaxQuads);
                        r_job.has_quad     <= (i_item.opcode == sqb_pkg::OpSubmit);
                        r_job.flush_idx    <= sqb_pkg::six_times(r_quads);
                        r_job.flush_slots  <= 6'(r_slots_used);
                        r_tex              <= i_item.texture_id;
                        r_idx              <= sqb_pkg::SlotCntW'(1);
                        if (i_item.opcode == sqb_pkg::OpEndScene) begin
                            r_slots_used    <= sqb_pkg::SlotCntW'(1);
                            r_quads         <= '0;
                            r_state         <= F_PUSH;
                        end else begin
                            if (32'(r_quads) >= sqb_pkg::MaxQuads) begin
                                r_slots_used    <= sqb_pkg::SlotCntW'(1);
                                r_quads         <= '0;
                            end
                            r_state <= (i_item.texture_id == '0) ? F_PUSH : F_SEARCH;
                        end
                    end
                end
                F_SEARCH: begin
                    if (r_idx >= r_slots_used) begin
                        r_state <= F_PUSH;
                        if (32'(r_slots_used) >= sqb_pkg::MaxSlots) begin
                            r_job.has_flush   <= 1'b1;
                            r_job.flush_idx   <= sqb_pkg::six_times(r_quads);
                            r_job.flush_slots <= 6'(r_slots_used);
                            r_table[1]        <= r_tex;
                            r_job.slot        <= 5'd1;
                            r_slots_used      <= sqb_pkg::SlotCntW'(2);
                            r_quads           <= '0;
                        end else begin
                            r_table[r_slots_used[sqb_pkg::SlotIdxW-1:0]] <= r_tex;
                            r_job.slot   <= 5'(r_slots_used);
                            r_slots_used <= r_slots_used + sqb_pkg::SlotCntW'(1);
                        end
                    end else if (r_table[r_idx[sqb_pkg::SlotIdxW-1:0]] == r_tex) begin
                        r_job.slot <= 5'(r_idx);
                        r_state    <= F_PUSH;
                    end else begin
                        r_idx <= r_idx + sqb_pkg::SlotCntW'(1);
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        if (r_job.has_quad) begin
                            r_quads <= r_quads + sqb_pkg::QuadW'(1);
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/sqb_fifo.sv -----
module sqb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sqb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sqb_pkg::t_job o_job
);

    sqb_pkg::t_job                r_mem [sqb_pkg::FifoDepth];
    logic [sqb_pkg::FifoPtrW-1:0] r_wp;
    logic [sqb_pkg::FifoPtrW-1:0] r_rp;
    logic [sqb_pkg::FifoCntW-1:0] r_cnt;
    logic                         w_push;
    logic                         w_pop;

    assign o_full  = (32'(r_cnt) == sqb_pkg::FifoDepth);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_job;
                r_wp <= (32'(r_wp) == sqb_pkg::FifoDepth - 1) ? '0
                                                               : r_wp + sqb_pkg::FifoPtrW'(1);
            end
            if (w_pop) begin
                r_rp <= (32'(r_rp) == sqb_pkg::FifoDepth - 1) ? '0
                                                               : r_rp + sqb_pkg::FifoPtrW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + sqb_pkg::FifoCntW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - sqb_pkg::FifoCntW'(1);
            end
        end
    end

endmodule

// ----- sv/sqb_back.sv -----
module sqb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sqb_pkg::t_job i_job,
    output logic          o_pop,
    sqb_out_if.source     o_res
);

    typedef enum logic [1:0] {B_IDLE, B_MUL, B_EMIT} t_bstate;

    t_bstate            r_state;
    sqb_pkg::t_job      r_job;
    logic signed [17:0] r_sin;
    logic signed [17:0] r_cos;
    logic signed [49:0] r_xc;
    logic signed [49:0] r_ys;
    logic signed [49:0] r_xs;
    logic signed [49:0] r_yc;
    logic               r_flush_pend;
    logic [1:0]         r_k;
    logic               r_ovalid;
    sqb_pkg::t_res      r_res;

    logic               w_load;
    logic               w_neg_x;
    logic               w_neg_y;
    logic signed [50:0] w_vx;
    logic signed [50:0] w_vy;
    logic signed [50:0] w_ox;
    logic signed [50:0] w_oy;
    logic [31:0]        w_tc;

    assign o_pop  = (r_state == B_IDLE) && !i_empty;
    assign w_load = (r_state == B_EMIT) && (!r_ovalid || o_res.ready);

    always_comb begin
        w_neg_x = r_k[1];
        w_neg_y = r_k[1] ^ r_k[0];
        w_vx = (w_neg_x ? -51'(r_xc) : 51'(r_xc)) - (w_neg_y ? -51'(r_ys) : 51'(r_ys));
        w_vy = (w_neg_x ? -51'(r_xs) : 51'(r_xs)) + (w_neg_y ? -51'(r_yc) : 51'(r_yc));
        w_ox = (w_vx + 51'sd65536) >>> 17;
        w_oy = (w_vy + 51'sd65536) >>> 17;
        case (r_k)
            2'd0:    w_tc = r_job.coords_right[31:0];
            2'd1:    w_tc = r_job.coords_right[63:32];
            2'd2:    w_tc = r_job.coords_left[31:0];
            default: w_tc = r_job.coords_left[63:32];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_res.ready && !w_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_sin   <= sqb_pkg::sine_q16(i_job.angle);
                        r_cos   <= sqb_pkg::sine_q16(i_job.angle + 16'd16384);
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_xc         <= r_job.scale_x * r_cos;
                    r_ys         <= r_job.scale_y * r_sin;
                    r_xs         <= r_job.scale_x * r_sin;
                    r_yc         <= r_job.scale_y * r_cos;
                    r_flush_pend <= r_job.has_flush;
                    r_k          <= 2'd0;
                    r_state      <= B_EMIT;
                end
                B_EMIT: begin
                    if (w_load) begin
                        r_ovalid <= 1'b1;
                        if (r_flush_pend) begin
                            r_res.kind            <= sqb_pkg::KindFlush;
                            r_res.vert_x          <= '0;
                            r_res.vert_y          <= '0;
                            r_res.vert_z          <= '0;
                            r_res.packed_color    <= '0;
                            r_res.tex_coord       <= '0;
                            r_res.slot            <= '0;
                            r_res.flushed_indices <= r_job.flush_idx;
                            r_res.slots_in_use    <= r_job.flush_slots;
                            r_res.last            <= !r_job.has_quad;
                            r_flush_pend          <= 1'b0;
                            if (!r_job.has_quad) begin
                                r_state <= B_IDLE;
                            end
                        end else begin
                            r_res.kind            <= sqb_pkg::KindVertex;
                            r_res.vert_x          <= r_job.pos_x + w_ox[31:0];
                            r_res.vert_y          <= r_job.pos_y + w_oy[31:0];
                            r_res.vert_z          <= r_job.pos_z;
                            r_res.packed_color    <= r_job.color;
                            r_res.tex_coord       <= w_tc;
                            r_res.slot            <= r_job.slot;
                            r_res.flushed_indices <= '0;
                            r_res.slots_in_use    <= '0;
                            r_res.last            <= (r_k == 2'd3);
                            r_k                   <= r_k + 2'd1;
                            if (r_k == 2'd3) begin
                                r_state <= B_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.kind            = r_res.kind;
    assign o_res.vert_x          = r_res.vert_x;
    assign o_res.vert_y          = r_res.vert_y;
    assign o_res.vert_z          = r_res.vert_z;
    assign o_res.packed_color    = r_res.packed_color;
    assign o_res.tex_coord       = r_res.tex_coord;
    assign o_res.slot            = r_res.slot;
    assign o_res.flushed_indices = r_res.flushed_indices;
    assign o_res.slots_in_use    = r_res.slots_in_use;
    assign o_res.last            = r_res.last;

endmodule

// ----- sv/sprite_quad_batcher.sv -----
// Sprite batcher: each submit transaction yields four vertex transactions (top-right,
// bottom-right, bottom-left, top-left), preceded by one flush transaction when the quad
// limit or the texture slot table is full; an end-scene transaction yields one flush.
// The front end registers a sprite and then looks a nonzero texture id up one slot per
// cycle among the slots in use; texture id zero takes slot zero without a search.
// The back end does the sine lookup in its idle state and the products in its multiply
// state, then loads each result into the output register when it is empty or being
// taken. A two-entry queue between the two ends lets the lookup of the next sprite
// overlap the output of the current one.
module sprite_quad_batcher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sqb_in_if.sink    i_item,
    sqb_out_if.source o_res
);

    sqb_pkg::t_job w_front_job;
    sqb_pkg::t_job w_head_job;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;

    sqb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_job   (w_front_job),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    sqb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    sqb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

// ----- sv/sqb_checker.sv -----
`include "assert_macros.svh"

module sqb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_kind,
    input logic [31:0] i_vert_x,
    input logic [31:0] i_vert_z,
    input logic [4:0]  i_slot,
    input logic [12:0] i_flushed_indices,
    input logic [5:0]  i_slots_in_use
);

    `SQB_ASSERT(a_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(i_kind), "result dropped while stalled")
    `SQB_ASSERT(a_flush_clean, i_clk, i_rst_n, i_valid && i_kind |-> i_vert_x == 0 && i_vert_z == 0 && i_slot == 0, "flush carries vertex data")
    `SQB_ASSERT(a_vertex_clean, i_clk, i_rst_n, i_valid && !i_kind |-> i_flushed_indices == 0 && i_slots_in_use == 0, "vertex carries flush data")
    `SQB_ASSERT(a_flush_range, i_clk, i_rst_n, i_valid && i_kind |-> i_slots_in_use != 0 && i_slots_in_use <= 6'd32 && i_flushed_indices <= 13'd6144, "flush counts out of range")

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_res.valid),
    .i_ready           (o_res.ready),
    .i_kind            (o_res.kind),
    .i_vert_x          (o_res.vert_x),
    .i_vert_z          (o_res.vert_z),
    .i_slot            (o_res.slot),
    .i_flushed_indices (o_res.flushed_indices),
    .i_slots_in_use    (o_res.slots_in_use)
);
